@@ rtl/calc_pkg.sv @@
// Shared types and constants for the calculator ALU.
// Holds operation and status codes plus the command and status bundles
// that join the controller to the datapath. No dependencies.
package calc_pkg;

    // Operation codes carried on the request.
    localparam logic [2:0] FN_ADD  = 3'd1;
    localparam logic [2:0] FN_SUB  = 3'd2;
    localparam logic [2:0] FN_MUL  = 3'd3;
    localparam logic [2:0] FN_DIV  = 3'd4;
    localparam logic [2:0] FN_POW  = 3'd5;
    localparam logic [2:0] FN_FACT = 3'd6;

    // Status codes carried on the result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIV0  = 2'd1;
    localparam logic [1:0] ST_BADOP = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Multiplier digit width: one multiplier chunk per cycle.
    localparam int MUL_CHUNK = 16;

    // What the datapath writes into the result register.
    typedef enum logic [2:0] {
        RES_ADD,
        RES_SUB,
        RES_MUL,
        RES_DIV,
        RES_DIV0,
        RES_BADOP,
        RES_ONE,
        RES_ACC
    } res_op_t;

    // Operand pair handed to the shared multiplier.
    typedef enum logic [1:0] {
        MS_FIX,
        MS_ACC_SQ,
        MS_SQ_SQ,
        MS_ACC_CNT
    } mul_src_t;

    // Where a finished product is written back.
    typedef enum logic [1:0] {
        WB_ACC,
        WB_SQ,
        WB_FACT
    } wb_t;

    typedef struct packed {
        logic     load_in;
        logic     res_we;
        res_op_t  res_op;
        logic     mul_start;
        mul_src_t mul_src;
        logic     div_start;
        logic     acc_init;
        logic     wb_we;
        wb_t      wb;
        logic     out_load;
    } calc_cmd_t;

    typedef struct packed {
        logic a_nonpos;
        logic b_nonpos;
        logic b_zero;
        logic e_lsb;
        logic fact_end;
        logic mul_done;
        logic div_done;
    } calc_stat_t;

endpackage

@@ rtl/calculator_alu.sv @@
// Calculator ALU. Add, subtract and invalid codes need no iterative unit; multiply
// runs the shared multiplier once, divide is set by the one-bit-per-cycle divider,
// and power and factorial are both bound by the shared multiplier. A new request
// is taken in the cycle after the result is loaded. Reset is synchronous, active low.
module calculator_alu
    import calc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_func,
    input  logic signed [DATA_WIDTH-1:0] s_operand_a,
    input  logic signed [DATA_WIDTH-1:0] s_operand_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_result_value,
    output logic [1:0]                   m_status
);

    calc_cmd_t  cmd;
    calc_stat_t stat;

    // Sequencer.
    calc_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

    // Arithmetic and result registers.
    calc_dp #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .operand_a   (s_operand_a),
        .operand_b   (s_operand_b),
        .result_value(m_result_value),
        .status      (m_status)
    );

endmodule

@@ rtl/calc_mul.sv @@
// Shared iterative multiplier: one 16-bit digit of y per cycle.
// Unsigned DW x DW product, full 2*DW bits. Uses calc_pkg.
module calc_mul
    import calc_pkg::*;
#(
    parameter int DW = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [DW-1:0]   x,
    input  logic [DW-1:0]   y,
    output logic [2*DW-1:0] prod,
    output logic            done
);

    localparam int STEPS = (DW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW    = STEPS * MUL_CHUNK;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DW-1:0]           x_reg;
    logic [DW-1:0]           hi_reg;
    logic [PW-1:0]           lo_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DW+MUL_CHUNK-1:0] pp;
    logic [DW+MUL_CHUNK-1:0] t;
    logic [PW+MUL_CHUNK-1:0] shifted;
    logic [DW+PW-1:0]        full;
    logic                    last;

    // One partial product per cycle, added to the running high half.
    assign pp      = x_reg * lo_reg[MUL_CHUNK-1:0];
    assign t       = pp + (DW+MUL_CHUNK)'(hi_reg);
    assign shifted = {t[MUL_CHUNK-1:0], lo_reg};
    assign last    = (cnt_reg == CW'(STEPS - 1));

    // Control: step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Data: the low digits shift out of lo_reg as product bits shift in.
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg  <= x;
            hi_reg <= '0;
            lo_reg <= PW'(y);
        end else if (busy_reg) begin
            hi_reg <= t[DW+MUL_CHUNK-1:MUL_CHUNK];
            lo_reg <= shifted[PW+MUL_CHUNK-1:MUL_CHUNK];
        end
    end

    assign full = {hi_reg, lo_reg};
    assign prod = full[2*DW-1:0];
    assign done = done_reg;

endmodule

@@ rtl/calc_div.sv @@
// Restoring divider, one quotient bit per cycle, NW quotient bits in all.
// Unsigned NW-bit dividend by DW-bit divisor. Uses calc_pkg for style only.
module calc_div
    import calc_pkg::*;
#(
    parameter int DW = 32,
    parameter int NW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quot,
    output logic          done
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   r2;
    logic [DW:0]   diff;
    logic          fits;
    logic          last;

    // Trial subtraction of the divisor from the shifted remainder.
    assign r2   = {rem_reg, q_reg[NW-1]};
    assign fits = (r2 >= {1'b0, d_reg});
    assign diff = r2 - {1'b0, d_reg};
    assign last = (cnt_reg == CW'(NW - 1));

    // Control: bit counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Data: dividend bits leave the top of q_reg as quotient bits enter.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NW-2:0], fits};
            rem_reg <= fits ? diff[DW-1:0] : r2[DW-1:0];
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

@@ rtl/calc_dp.sv @@
// Datapath of the calculator ALU: operand, accumulator and result
// registers, saturating pack, shared multiplier and divider.
// Depends on calc_pkg, calc_mul and calc_div.
module calc_dp
    import calc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  calc_cmd_t                    cmd,
    output calc_stat_t                   stat,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic signed [DATA_WIDTH-1:0] result_value,
    output logic [1:0]                   status
);

    localparam int DW = DATA_WIDTH;
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int MW = (2 * DW > NW) ? 2 * DW : NW;
    localparam logic [DW-1:0] SIGN_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] MAX_POS  = {1'b0, {(DW-1){1'b1}}};

    logic [DW-1:0]   a_reg;
    logic [DW-1:0]   b_reg;
    logic [DW-1:0]   acc_reg;
    logic [DW-1:0]   cnt_reg;
    logic [DW-1:0]   res_reg;
    logic [1:0]      st_reg;
    logic [DW-1:0]   out_val_reg;
    logic [1:0]      out_st_reg;

    logic [DW-1:0]   a_mag;
    logic [DW-1:0]   b_mag;
    logic            neg;
    logic [DW-1:0]   sum;
    logic [DW-1:0]   dif;
    logic [DW-1:0]   mul_x;
    logic [DW-1:0]   mul_y;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] prod_shift;
    logic            mul_done;
    logic [NW-1:0]   dividend;
    logic [NW-1:0]   quot;
    logic            div_done;
    logic [MW-1:0]   mag;
    logic [DW-1:0]   packed_val;
    logic            packed_sat;
    logic [DW-1:0]   res_val;
    logic [1:0]      res_st;

    // Operand magnitudes and result sign for multiply and divide.
    assign a_mag = a_reg[DW-1] ? (~a_reg + 1'b1) : a_reg;
    assign b_mag = b_reg[DW-1] ? (~b_reg + 1'b1) : b_reg;
    assign neg   = a_reg[DW-1] ^ b_reg[DW-1];
    assign sum   = a_reg + b_reg;
    assign dif   = a_reg - b_reg;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (cmd.mul_src)
            MS_FIX: begin
                mul_x = a_mag;
                mul_y = b_mag;
            end
            MS_ACC_SQ: begin
                mul_x = acc_reg;
                mul_y = a_reg;
            end
            MS_SQ_SQ: begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            MS_ACC_CNT: begin
                mul_x = acc_reg;
                mul_y = cnt_reg;
            end
            default: begin
                mul_x = a_mag;
                mul_y = b_mag;
            end
        endcase
    end

    calc_mul #(
        .DW(DW)
    ) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.mul_start),
        .x      (mul_x),
        .y      (mul_y),
        .prod   (prod),
        .done   (mul_done)
    );

    assign dividend = NW'(a_mag) << FRAC_BITS;

    calc_div #(
        .DW(DW),
        .NW(NW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(dividend),
        .divisor (b_mag),
        .quot    (quot),
        .done    (div_done)
    );

    // Saturating pack of a fixed-point magnitude into a signed word.
    assign prod_shift = prod >> FRAC_BITS;
    assign mag        = (cmd.res_op == RES_DIV) ? MW'(quot) : MW'(prod_shift);

    always_comb begin
        if (neg) begin
            packed_sat = (mag > MW'(SIGN_MIN));
            packed_val = packed_sat ? SIGN_MIN : (~mag[DW-1:0] + 1'b1);
        end else begin
            packed_sat = (mag > MW'(MAX_POS));
            packed_val = packed_sat ? MAX_POS : mag[DW-1:0];
        end
    end

    // Result selection.
    always_comb begin
        res_val = '0;
        res_st  = ST_OK;
        case (cmd.res_op)
            RES_ADD: begin
                if ((a_reg[DW-1] == b_reg[DW-1]) && (sum[DW-1] != a_reg[DW-1])) begin
                    res_val = a_reg[DW-1] ? SIGN_MIN : MAX_POS;
                    res_st  = ST_SAT;
                end else begin
                    res_val = sum;
                end
            end
            RES_SUB: begin
                if ((a_reg[DW-1] != b_reg[DW-1]) && (dif[DW-1] != a_reg[DW-1])) begin
                    res_val = a_reg[DW-1] ? SIGN_MIN : MAX_POS;
                    res_st  = ST_SAT;
                end else begin
                    res_val = dif;
                end
            end
            RES_MUL, RES_DIV: begin
                res_val = packed_val;
                res_st  = packed_sat ? ST_SAT : ST_OK;
            end
            RES_DIV0: begin
                res_val = '0;
                res_st  = ST_DIV0;
            end
            RES_BADOP: begin
                res_val = '0;
                res_st  = ST_BADOP;
            end
            RES_ONE: begin
                res_val = DW'(1);
            end
            RES_ACC: begin
                res_val = acc_reg;
            end
            default: begin
                res_val = '0;
                res_st  = ST_BADOP;
            end
        endcase
    end

    // Working registers: operands, power and factorial state, results.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg <= operand_a;
            b_reg <= operand_b;
        end
        if (cmd.acc_init) begin
            acc_reg <= DW'(1);
            cnt_reg <= DW'(1);
        end
        if (cmd.wb_we) begin
            case (cmd.wb)
                WB_ACC: begin
                    acc_reg <= prod[DW-1:0];
                end
                WB_SQ: begin
                    a_reg <= prod[DW-1:0];
                    b_reg <= b_reg >> 1;
                end
                WB_FACT: begin
                    acc_reg <= prod[DW-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        if (cmd.res_we) begin
            res_reg <= res_val;
            st_reg  <= res_st;
        end
        if (cmd.out_load) begin
            out_val_reg <= res_reg;
            out_st_reg  <= st_reg;
        end
    end

    // Status back to the controller.
    assign stat.a_nonpos = a_reg[DW-1] || (a_reg == '0);
    assign stat.b_nonpos = b_reg[DW-1] || (b_reg == '0);
    assign stat.b_zero   = (b_reg == '0);
    assign stat.e_lsb    = b_reg[0];
    assign stat.fact_end = (acc_reg == '0) || (cnt_reg > a_reg);
    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;

    assign result_value = out_val_reg;
    assign status       = out_st_reg;

endmodule

@@ rtl/calc_ctrl.sv @@
// Controller of the calculator ALU: sequences each request through the
// datapath and drives the request and result handshakes. Depends on calc_pkg.
module calc_ctrl
    import calc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    output logic       m_valid,
    input  logic       m_ready,
    output calc_cmd_t  cmd,
    input  calc_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FMUL_WAIT,
        S_DIV_WAIT,
        S_POW_STEP,
        S_POW_ACC_WAIT,
        S_POW_SQ_WAIT,
        S_FACT_STEP,
        S_FACT_WAIT,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] func_reg;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.load_in   = 1'b0;
        cmd.res_we    = 1'b0;
        cmd.res_op    = RES_BADOP;
        cmd.mul_start = 1'b0;
        cmd.mul_src   = MS_FIX;
        cmd.div_start = 1'b0;
        cmd.acc_init  = 1'b0;
        cmd.wb_we     = 1'b0;
        cmd.wb        = WB_ACC;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (func_reg)
                    FN_ADD: begin
                        cmd.res_we = 1'b1;
                        cmd.res_op = RES_ADD;
                        state_next = S_DONE;
                    end
                    FN_SUB: begin
                        cmd.res_we = 1'b1;
                        cmd.res_op = RES_SUB;
                        state_next = S_DONE;
                    end
                    FN_MUL: begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_src   = MS_FIX;
                        state_next    = S_FMUL_WAIT;
                    end
                    FN_DIV: begin
                        if (stat.b_zero) begin
                            cmd.res_we = 1'b1;
                            cmd.res_op = RES_DIV0;
                            state_next = S_DONE;
                        end else begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_WAIT;
                        end
                    end
                    FN_POW: begin
                        if (stat.b_nonpos) begin
                            cmd.res_we = 1'b1;
                            cmd.res_op = RES_ONE;
                            state_next = S_DONE;
                        end else begin
                            cmd.acc_init = 1'b1;
                            state_next   = S_POW_STEP;
                        end
                    end
                    FN_FACT: begin
                        if (stat.a_nonpos) begin
                            cmd.res_we = 1'b1;
                            cmd.res_op = RES_ONE;
                            state_next = S_DONE;
                        end else begin
                            cmd.acc_init = 1'b1;
                            state_next   = S_FACT_STEP;
                        end
                    end
                    default: begin
                        cmd.res_we = 1'b1;
                        cmd.res_op = RES_BADOP;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FMUL_WAIT: begin
                cmd.res_op = RES_MUL;
                if (stat.mul_done) begin
                    cmd.res_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DIV_WAIT: begin
                cmd.res_op = RES_DIV;
                if (stat.div_done) begin
                    cmd.res_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            // Square-and-multiply, least significant exponent bit first.
            S_POW_STEP: begin
                if (stat.b_zero) begin
                    cmd.res_we = 1'b1;
                    cmd.res_op = RES_ACC;
                    state_next = S_DONE;
                end else if (stat.e_lsb) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MS_ACC_SQ;
                    state_next    = S_POW_ACC_WAIT;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MS_SQ_SQ;
                    state_next    = S_POW_SQ_WAIT;
                end
            end
            S_POW_ACC_WAIT: begin
                cmd.mul_src = MS_SQ_SQ;
                if (stat.mul_done) begin
                    cmd.wb_we     = 1'b1;
                    cmd.wb        = WB_ACC;
                    cmd.mul_start = 1'b1;
                    state_next    = S_POW_SQ_WAIT;
                end
            end
            S_POW_SQ_WAIT: begin
                if (stat.mul_done) begin
                    cmd.wb_we  = 1'b1;
                    cmd.wb     = WB_SQ;
                    state_next = S_POW_STEP;
                end
            end
            // Running product stops once the count passes the operand or the product wraps to zero.
            S_FACT_STEP: begin
                if (stat.fact_end) begin
                    cmd.res_we = 1'b1;
                    cmd.res_op = RES_ACC;
                    state_next = S_DONE;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_src   = MS_ACC_CNT;
                    state_next    = S_FACT_WAIT;
                end
            end
            S_FACT_WAIT: begin
                if (stat.mul_done) begin
                    cmd.wb_we  = 1'b1;
                    cmd.wb     = WB_FACT;
                    state_next = S_FACT_STEP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, latched operation code and the result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            func_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                func_reg <= s_func;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/calc_chk.sv @@
// Port-level checker for the calculator ALU, bound to the top level.
// Depends on calc_pkg and calculator_alu.
module calc_chk
    import calc_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [DATA_WIDTH-1:0] m_result_value,
    input logic [1:0]            m_status
);

    localparam logic [DATA_WIDTH-1:0] SIGN_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value) && $stable(m_status))
        else $error("result changed while stalled");

    // One request at a time: no acceptance in the cycle after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // Error codes carry a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DIV0 || m_status == ST_BADOP) |-> m_result_value == '0)
        else $error("error result not zero");

    // Saturation gives one of the two limits.
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_SAT |-> m_result_value == SIGN_MIN || m_result_value == MAX_POS)
        else $error("saturated result not at a limit");

    // Reset empties the result channel and readies the input.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset state wrong");

endmodule

bind calculator_alu calc_chk #(
    .DATA_WIDTH(DATA_WIDTH)
) u_calc_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_value(m_result_value),
    .m_status      (m_status)
);

@@ verif/tb_calculator_alu.sv @@
// Self-checking testbench for calculator_alu: directed table, then random requests.
// Expected results come from a behavioural predictor written here in SystemVerilog.
// Depends on rtl/calc_pkg.sv and rtl/calculator_alu.sv.
`timescale 1ns / 1ps

module tb_calculator_alu;
    import calc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PER_PHASE = 406;
    localparam int NUM_PHASES     = 4;
    localparam int NUM_DIRECTED   = 26;

    // Codes the package leaves unnamed: both are invalid operations.
    localparam logic [2:0] FN_NONE  = 3'd0;
    localparam logic [2:0] FN_SPARE = 3'd7;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } alu_result_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;
        logic [31:0] value;
        logic [1:0]  status;
    } stimulus_row_t;

    // Directed rows; where known is set the expected result is given in the row.
    stimulus_row_t directed_rows [NUM_DIRECTED] = '{
        '{FN_ADD,   32'h0001_0000, 32'h0002_8000, 1'b0, 32'd0, ST_OK},
        '{FN_ADD,   WORD_MAX,      WORD_MAX,      1'b1, WORD_MAX, ST_SAT},
        '{FN_ADD,   WORD_MIN,      WORD_MIN,      1'b1, WORD_MIN, ST_SAT},
        '{FN_SUB,   WORD_MIN,      32'h0000_0001, 1'b1, WORD_MIN, ST_SAT},
        '{FN_SUB,   WORD_MAX,      32'hFFFF_FFFF, 1'b1, WORD_MAX, ST_SAT},
        '{FN_SUB,   32'h0003_0000, 32'h0005_4000, 1'b0, 32'd0, ST_OK},
        '{FN_MUL,   32'hFFFE_8000, 32'h0002_0000, 1'b0, 32'd0, ST_OK},
        '{FN_MUL,   WORD_MAX,      WORD_MAX,      1'b0, 32'd0, ST_OK},
        '{FN_MUL,   WORD_MIN,      WORD_MIN,      1'b0, 32'd0, ST_OK},
        '{FN_MUL,   WORD_MIN,      32'h0001_0000, 1'b0, 32'd0, ST_OK},
        '{FN_MUL,   32'hFFFF_FFFF, 32'h0000_8000, 1'b0, 32'd0, ST_OK},
        '{FN_DIV,   32'h0001_0000, 32'h0003_0000, 1'b0, 32'd0, ST_OK},
        '{FN_DIV,   WORD_MIN,      32'hFFFF_FFFF, 1'b0, 32'd0, ST_OK},
        '{FN_DIV,   32'hFFF9_0000, 32'h0000_0000, 1'b1, 32'd0, ST_DIV0},
        '{FN_DIV,   WORD_MAX,      WORD_MAX,      1'b0, 32'd0, ST_OK},
        '{FN_POW,   32'h0000_0003, 32'h0000_0000, 1'b1, 32'd1, ST_OK},
        '{FN_POW,   32'h0000_0002, 32'hFFFF_FFFF, 1'b1, 32'd1, ST_OK},
        '{FN_POW,   32'h0000_0003, 32'h0000_0013, 1'b0, 32'd0, ST_OK},
        '{FN_POW,   32'hFFFF_FFFF, WORD_MAX,      1'b0, 32'd0, ST_OK},
        '{FN_FACT,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd1, ST_OK},
        '{FN_FACT,  WORD_MIN,      32'h0000_0000, 1'b1, 32'd1, ST_OK},
        '{FN_FACT,  32'd12,        WORD_MIN,      1'b1, 32'd479001600, ST_OK},
        '{FN_FACT,  32'd13,        32'h0000_0000, 1'b0, 32'd0, ST_OK},
        '{FN_FACT,  WORD_MAX,      WORD_MAX,      1'b0, 32'd0, ST_OK},
        '{FN_NONE,  WORD_MAX,      WORD_MIN,      1'b1, 32'd0, ST_BADOP},
        '{FN_SPARE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0, ST_BADOP}
    };

    localparam logic [2:0] VALID_OPS [6] = '{FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_POW, FN_FACT};

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func         = '0;
    logic signed [31:0] s_operand_a    = '0;
    logic signed [31:0] s_operand_b    = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_result_value;
    logic [1:0]         m_status;

    alu_result_t offered_result = '0;
    alu_result_t awaited_results [$];
    logic        hold_pending   = 1'b0;
    logic        hold_done      = 1'b0;
    int          send_idle_pct  = 0;
    int          stall_pct      = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;

    calculator_alu dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_operand_a    (s_operand_a),
        .s_operand_b    (s_operand_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Magnitude of a two's complement word; the most negative word maps to 2^31.
    function automatic logic [31:0] abs_word(input logic [31:0] w);
        return w[31] ? -w : w;
    endfunction

    // Fit a signed magnitude into a word, saturating and flagging when it does not fit.
    function automatic logic [31:0] fit_magnitude(input logic neg, input logic [63:0] mag,
                                                  inout logic [1:0] st);
        if (neg) begin
            if (mag > {32'd0, WORD_MIN}) begin
                st = ST_SAT;
                return WORD_MIN;
            end
            return -mag[31:0];
        end
        if (mag > {32'd0, WORD_MAX}) begin
            st = ST_SAT;
            return WORD_MAX;
        end
        return mag[31:0];
    endfunction

    // Behavioural prediction of one request.
    function automatic alu_result_t compute_alu_result(input logic [2:0] op,
                                                       input logic [31:0] a,
                                                       input logic [31:0] b);
        alu_result_t res;
        logic [63:0] wide;
        logic [31:0] acc;
        logic [31:0] sq;
        logic [31:0] e;
        logic [31:0] n;
        logic [1:0]  st;
        st  = ST_OK;
        acc = 32'd1;
        case (op)
            FN_ADD: begin
                acc = a + b;
                if (a[31] == b[31] && acc[31] != a[31]) begin
                    st  = ST_SAT;
                    acc = a[31] ? WORD_MIN : WORD_MAX;
                end
            end
            FN_SUB: begin
                acc = a - b;
                if (a[31] != b[31] && acc[31] != a[31]) begin
                    st  = ST_SAT;
                    acc = a[31] ? WORD_MIN : WORD_MAX;
                end
            end
            FN_MUL: begin
                wide = {32'd0, abs_word(a)} * {32'd0, abs_word(b)};
                acc  = fit_magnitude(a[31] ^ b[31], wide >> 16, st);
            end
            FN_DIV: begin
                if (b == 32'd0) begin
                    acc = 32'd0;
                    st  = ST_DIV0;
                end else begin
                    wide = {16'd0, abs_word(a), 16'd0} / {32'd0, abs_word(b)};
                    acc  = fit_magnitude(a[31] ^ b[31], wide, st);
                end
            end
            FN_POW: begin
                // Square and multiply, wrapping at the word width.
                if (!b[31] && b != 32'd0) begin
                    sq = a;
                    e  = b;
                    while (e != 32'd0) begin
                        if (e[0]) acc = acc * sq;
                        sq = sq * sq;
                        e  = e >> 1;
                    end
                end
            end
            FN_FACT: begin
                // The product stays zero once 2^32 divides it, so the loop stops there.
                if (!a[31] && a != 32'd0) begin
                    for (n = 32'd1; n <= a && acc != 32'd0; n++) acc = acc * n;
                end
            end
            default: begin
                acc = 32'd0;
                st  = ST_BADOP;
            end
        endcase
        res.value  = acc;
        res.status = st;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offer one request, with a random idle gap first, and wait until it is accepted.
    task automatic send_request(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b,
                                input alu_result_t want);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_func         <= op;
        s_operand_a    <= a;
        s_operand_b    <= b;
        offered_result <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Operand mix: full range, small and medium fixed-point values, extremes and shifted words, each negated at random.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 5))
            0, 3: w = $urandom;
            1: w = $urandom_range(0, 32'h3_FFFF);
            2: begin
                case ($urandom_range(0, 6))
                    0: w = WORD_MAX;
                    1: w = WORD_MIN;
                    2: w = 32'd0;
                    3: w = 32'd1;
                    4: w = 32'hFFFF_FFFF;
                    5: w = 32'h0001_0000;
                    default: w = 32'hFFFF_0000;
                endcase
            end
            4: w = $urandom_range(0, 32'h7F_FFFF);
            default: w = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) == 1) w = -w;
        return w;
    endfunction

    task automatic send_random_request();
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        if ($urandom_range(0, 9) == 0) op = $urandom_range(0, 1) ? FN_SPARE : FN_NONE;
        else op = VALID_OPS[$urandom_range(0, 5)];
        a = random_word();
        b = random_word();
        // Power and factorial mostly use short counts, where the arithmetic is visible.
        if (op == FN_POW && $urandom_range(0, 3) != 0) b = $urandom_range(0, 40);
        if (op == FN_FACT && $urandom_range(0, 3) != 0) a = $urandom_range(0, 40);
        send_request(op, a, b, compute_alu_result(op, a, b));
    endtask

    // Receiver: random stalls, plus one long hold-off once it is asked for.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_pending && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done <= 1'b1;
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Scoreboard: record accepted requests and check each result against the oldest one.
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result %h status %0d with nothing awaited",
                                              m_result_value, m_status));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch($sformatf("result_value %h, expected %h",
                                                  m_result_value, want.value));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                end
            end
            if (s_valid && s_ready) awaited_results.push_back(offered_result);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_rows[i].known)
                send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                             alu_result_t'{directed_rows[i].value, directed_rows[i].status});
            else
                send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                             compute_alu_result(directed_rows[i].op, directed_rows[i].a,
                                                directed_rows[i].b));
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 73; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 73; end
                default: begin send_idle_pct = 32; stall_pct <= 32; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Midway through the first phase the receiver holds off while requests keep coming.
                if (phase == 0 && n == RANDOM_PER_PHASE / 2) hold_pending <= 1'b1;
                send_random_request();
            end
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
